// ===== design/calendar_date_stepper_top_macros.svh =====
// assertion macros for the checker in cds_checker.sv
`ifndef CALENDAR_DATE_STEPPER_TOP_MACROS_SVH
`define CALENDAR_DATE_STEPPER_TOP_MACROS_SVH

// property holds on every clock edge outside reset
`define CDS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds on the edge after the antecedent
`define CDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cds_pkg.sv =====
package cds_pkg;

   typedef enum logic [1:0] {
      OP_LOAD       = 2'd0,
      OP_ADD_DAYS   = 2'd1,
      OP_ADD_MONTHS = 2'd2,
      OP_ADD_YEARS  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REM,
      ST_STEP,
      ST_CLAMP
   } state_type;

   typedef struct packed {
      logic back;
      logic months;
   } step_ctl_type;

   localparam int AMT_BITS      = 13;
   localparam int DAY_BITS      = 5;
   localparam int MONTH_BITS    = 4;
   localparam int NEW_YEAR_BITS = 16;
   localparam int REM_BITS      = 9;

   localparam logic [DAY_BITS-1:0]   DAY_FIRST    = 5'd1;
   localparam logic [DAY_BITS-1:0]   DAY_DEC_LAST = 5'd31;
   localparam logic [DAY_BITS-1:0]   DAY_LEAP_FEB = 5'd29;
   localparam logic [MONTH_BITS-1:0] MONTH_JAN    = 4'd1;
   localparam logic [MONTH_BITS-1:0] MONTH_FEB    = 4'd2;
   localparam logic [MONTH_BITS-1:0] MONTH_DEC    = 4'd12;

   localparam logic [REM_BITS:0]   LEAP_CYCLE = 10'd400;
   localparam logic [REM_BITS-1:0] REM_TOP    = 9'd399;
   localparam logic [REM_BITS-1:0] REM_C100   = 9'd100;
   localparam logic [REM_BITS-1:0] REM_C200   = 9'd200;
   localparam logic [REM_BITS-1:0] REM_C300   = 9'd300;
   localparam logic [REM_BITS-1:0] REM_ONE    = 9'd1;

   localparam logic [DAY_BITS-1:0] MONTH_LEN [13] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // r is the year modulo 400
   function automatic logic is_leap(logic [REM_BITS-1:0] r);
      return (r[1:0] == 2'b00) && (r != REM_C100) && (r != REM_C200) && (r != REM_C300);
   endfunction

   function automatic logic [DAY_BITS-1:0] days_in(logic [MONTH_BITS-1:0] m, logic leap);
      logic [DAY_BITS-1:0] len;
      if ((m < MONTH_JAN) || (m > MONTH_DEC)) begin
         len = DAY_DEC_LAST;
      end else if ((m == MONTH_FEB) && leap) begin
         len = DAY_LEAP_FEB;
      end else begin
         len = MONTH_LEN[m];
      end
      return len;
   endfunction

endpackage

// ===== design/calendar_date_stepper_top.sv =====
// a load runs through the mod-400 unit, an add of years through that unit and then
// the day clamp, an add of days or months through the date stepper (an add of
// months then clamps the day); a zero day or month step and a year underflow answer without going busy
// one request at a time, busy stays high until the result; the three-stage
// mod-400 unit and the one-unit-per-cycle date stepper do this work
// reset: synchronous, date returns to 1 january year 1; results cannot be stalled
module calendar_date_stepper_top #(
   parameter int YEAR_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_op,
   input  logic signed [cds_pkg::AMT_BITS-1:0] req_amount,
   input  logic [cds_pkg::DAY_BITS-1:0]      req_new_day,
   input  logic [cds_pkg::MONTH_BITS-1:0]    req_new_month,
   input  logic [cds_pkg::NEW_YEAR_BITS-1:0] req_new_year,
   output logic                              rsp_valid,
   output logic [cds_pkg::DAY_BITS-1:0]      rsp_day_out,
   output logic [cds_pkg::MONTH_BITS-1:0]    rsp_month_out,
   output logic [YEAR_BITS-1:0]              rsp_year_out,
   output logic                              rsp_rejected,
   output logic                              rsp_clipped
);
   import cds_pkg::*;

   localparam int RW = (YEAR_BITS > NEW_YEAR_BITS) ? YEAR_BITS : NEW_YEAR_BITS;
   localparam int SW = YEAR_BITS + 2;
   localparam logic [YEAR_BITS-1:0] YEAR_TOP = '1;
   localparam logic [YEAR_BITS-1:0] YEAR_ONE = YEAR_BITS'(1);
   localparam logic [RW-1:0]        TOP_RW   = RW'(YEAR_TOP);

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   op_type                   req_op_t;
   step_ctl_type             ctl_ff, ctl_in;
   logic [AMT_BITS-1:0]      cnt_ff, cnt_in;
   logic [DAY_BITS-1:0]      day_ff, day_in;
   logic [MONTH_BITS-1:0]    month_ff, month_in;
   logic [YEAR_BITS-1:0]     year_ff, year_in;
   logic [REM_BITS-1:0]      yr400_ff, yr400_in;
   logic [DAY_BITS-1:0]      ld_day_ff, ld_day_in;
   logic [MONTH_BITS-1:0]    ld_month_ff, ld_month_in;
   logic [NEW_YEAR_BITS-1:0] ld_year_ff, ld_year_in;
   logic                     clip_pend_ff, clip_pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_rejected_ff, rsp_rejected_in;
   logic                     rsp_clipped_ff, rsp_clipped_in;

   logic                     accept;
   logic                     amt_zero;
   logic [AMT_BITS-1:0]      amt_raw;
   logic [AMT_BITS-1:0]      amt_mag;
   logic signed [SW-1:0]     ysum;
   logic                     y_under;
   logic                     y_over;
   logic [YEAR_BITS-1:0]     y_new;
   logic                     rem_start;
   logic [RW-1:0]            rem_value;
   logic                     rem_done;
   logic [REM_BITS-1:0]      rem;
   logic [RW-1:0]            ld_year_rw;
   logic                     load_ok;
   logic [DAY_BITS-1:0]      dim_cur;
   logic [DAY_BITS-1:0]      st_day;
   logic [MONTH_BITS-1:0]    st_month;
   logic [YEAR_BITS-1:0]     st_year;
   logic [REM_BITS-1:0]      st_yr400;
   logic                     st_clip;

   cds_rem400 #(
      .W (RW)
   ) u_rem (
      .clock (clock),
      .reset (reset),
      .start (rem_start),
      .value (rem_value),
      .done  (rem_done),
      .rem   (rem)
   );

   cds_step #(
      .YEAR_BITS (YEAR_BITS)
   ) u_step (
      .ctl      (ctl_ff),
      .day      (day_ff),
      .month    (month_ff),
      .year     (year_ff),
      .yr400    (yr400_ff),
      .day_nx   (st_day),
      .month_nx (st_month),
      .year_nx  (st_year),
      .yr400_nx (st_yr400),
      .clip     (st_clip)
   );

   always_comb begin
      accept   = start && (state_ff == ST_IDLE);
      req_op_t = op_type'(req_op);
      amt_raw  = req_amount;
      amt_zero = (amt_raw == '0);
      amt_mag  = amt_raw[AMT_BITS-1] ? (~amt_raw + 1'b1) : amt_raw;
      ysum     = $signed({2'b00, year_ff}) + SW'(req_amount);
      y_under  = ysum[SW-1] || (ysum == '0);
      y_over   = !ysum[SW-1] && ysum[SW-2];
      y_new    = y_over ? YEAR_TOP : ysum[YEAR_BITS-1:0];

      ld_year_rw = RW'(ld_year_ff);
      load_ok    = (ld_year_ff != '0) && (ld_year_rw <= TOP_RW)
                   && (ld_month_ff >= MONTH_JAN) && (ld_month_ff <= MONTH_DEC)
                   && (ld_day_ff != '0)
                   && (ld_day_ff <= days_in(ld_month_ff, is_leap(rem)));
      dim_cur    = days_in(month_ff, is_leap(yr400_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op_t)
                  OP_LOAD:                    state_in = ST_REM;
                  OP_ADD_DAYS, OP_ADD_MONTHS: state_in = amt_zero ? ST_IDLE : ST_STEP;
                  OP_ADD_YEARS:               state_in = y_under ? ST_IDLE : ST_REM;
                  default:                    state_in = ST_IDLE;
               endcase
            end
         end
         ST_REM: begin
            if (rem_done) begin
               state_in = (op_ff == OP_ADD_YEARS) ? ST_CLAMP : ST_IDLE;
            end
         end
         ST_STEP: begin
            if (st_clip) begin
               state_in = ST_IDLE;
            end else if (cnt_ff == AMT_BITS'(1)) begin
               state_in = (op_ff == OP_ADD_MONTHS) ? ST_CLAMP : ST_IDLE;
            end
         end
         ST_CLAMP: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      op_in           = op_ff;
      ctl_in          = ctl_ff;
      cnt_in          = cnt_ff;
      day_in          = day_ff;
      month_in        = month_ff;
      year_in         = year_ff;
      yr400_in        = yr400_ff;
      ld_day_in       = ld_day_ff;
      ld_month_in     = ld_month_ff;
      ld_year_in      = ld_year_ff;
      clip_pend_in    = clip_pend_ff;
      rsp_valid_in    = 1'b0;
      rsp_rejected_in = 1'b0;
      rsp_clipped_in  = 1'b0;
      rem_start       = 1'b0;
      rem_value       = RW'(req_new_year);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in        = req_op_t;
               ctl_in.back  = amt_raw[AMT_BITS-1];
               ctl_in.months = (req_op_t == OP_ADD_MONTHS);
               cnt_in       = amt_mag;
               ld_day_in    = req_new_day;
               ld_month_in  = req_new_month;
               ld_year_in   = req_new_year;
               clip_pend_in = 1'b0;
               unique case (req_op_t)
                  OP_LOAD: begin
                     rem_start = 1'b1;
                  end
                  OP_ADD_DAYS, OP_ADD_MONTHS: begin
                     rsp_valid_in = amt_zero;
                  end
                  OP_ADD_YEARS: begin
                     if (y_under) begin
                        day_in         = DAY_FIRST;
                        month_in       = MONTH_JAN;
                        year_in        = YEAR_ONE;
                        yr400_in       = REM_ONE;
                        rsp_valid_in   = 1'b1;
                        rsp_clipped_in = 1'b1;
                     end else begin
                        year_in      = y_new;
                        clip_pend_in = y_over;
                        rem_start    = 1'b1;
                        rem_value    = RW'(y_new);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_REM: begin
            if (rem_done) begin
               if (op_ff == OP_ADD_YEARS) begin
                  yr400_in = rem;
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_rejected_in = !load_ok;
                  if (load_ok) begin
                     day_in   = ld_day_ff;
                     month_in = ld_month_ff;
                     year_in  = ld_year_rw[YEAR_BITS-1:0];
                     yr400_in = rem;
                  end
               end
            end
         end
         ST_STEP: begin
            day_in   = st_day;
            month_in = st_month;
            year_in  = st_year;
            yr400_in = st_yr400;
            cnt_in   = cnt_ff - 1'b1;
            if (st_clip) begin
               rsp_valid_in   = 1'b1;
               rsp_clipped_in = 1'b1;
            end else if ((cnt_ff == AMT_BITS'(1)) && (op_ff != OP_ADD_MONTHS)) begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_CLAMP: begin
            if (day_ff > dim_cur) begin
               day_in = dim_cur;
            end
            rsp_valid_in   = 1'b1;
            rsp_clipped_in = clip_pend_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         day_ff       <= DAY_FIRST;
         month_ff     <= MONTH_JAN;
         year_ff      <= YEAR_ONE;
         yr400_ff     <= REM_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         yr400_ff     <= yr400_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      ctl_ff          <= ctl_in;
      cnt_ff          <= cnt_in;
      ld_day_ff       <= ld_day_in;
      ld_month_ff     <= ld_month_in;
      ld_year_ff      <= ld_year_in;
      clip_pend_ff    <= clip_pend_in;
      rsp_rejected_ff <= rsp_rejected_in;
      rsp_clipped_ff  <= rsp_clipped_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_day_out   = day_ff;
   assign rsp_month_out = month_ff;
   assign rsp_year_out  = year_ff;
   assign rsp_rejected  = rsp_rejected_ff;
   assign rsp_clipped   = rsp_clipped_ff;

endmodule

// ===== design/cds_rem400.sv =====
module cds_rem400 #(
   parameter int W = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [W-1:0]                  value,
   output logic                          done,
   output logic [cds_pkg::REM_BITS-1:0]  rem
);
   import cds_pkg::*;

   // year / 16 is divided by 25 through a reciprocal multiply, then the
   // remainder by 400 falls out of one subtraction in the low bits
   localparam int HW = W - 4;
   localparam int SH = HW + 5;
   localparam int MB = HW + 1;
   localparam int PW = HW + MB;
   localparam logic [63:0]         RECIP_WIDE = ((64'd1 << SH) + 64'd24) / 64'd25;
   localparam logic [MB-1:0]       RECIP      = RECIP_WIDE[MB-1:0];
   localparam logic [REM_BITS-1:0] CYCLE_LO   = LEAP_CYCLE[REM_BITS-1:0];

   logic [W-1:0]        val_ff, val_in;
   logic [W-1:0]        quo_ff, quo_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic                mul_ff;
   logic                sub_ff;
   logic                done_ff;
   logic [PW-1:0]       prod;
   logic [PW-1:0]       prod_sh;

   always_comb begin
      prod    = val_ff[W-1:4] * RECIP;
      prod_sh = prod >> SH;
      val_in  = start ? value : val_ff;
      quo_in  = mul_ff ? prod_sh[W-1:0] : quo_ff;
      // the true remainder is below 400, so modulo 512 arithmetic is exact
      rem_in  = sub_ff ? (val_ff[REM_BITS-1:0] - quo_ff[REM_BITS-1:0] * CYCLE_LO)
                       : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= start;
         sub_ff  <= mul_ff;
         done_ff <= sub_ff;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ===== design/cds_step.sv =====
module cds_step #(
   parameter int YEAR_BITS = 16
) (
   input  cds_pkg::step_ctl_type          ctl,
   input  logic [cds_pkg::DAY_BITS-1:0]   day,
   input  logic [cds_pkg::MONTH_BITS-1:0] month,
   input  logic [YEAR_BITS-1:0]           year,
   input  logic [cds_pkg::REM_BITS-1:0]   yr400,
   output logic [cds_pkg::DAY_BITS-1:0]   day_nx,
   output logic [cds_pkg::MONTH_BITS-1:0] month_nx,
   output logic [YEAR_BITS-1:0]           year_nx,
   output logic [cds_pkg::REM_BITS-1:0]   yr400_nx,
   output logic                           clip
);
   import cds_pkg::*;

   localparam logic [YEAR_BITS-1:0] YEAR_TOP = '1;
   localparam logic [YEAR_BITS-1:0] YEAR_ONE = YEAR_BITS'(1);

   logic                  leap;
   logic [DAY_BITS-1:0]   dim;
   logic [DAY_BITS-1:0]   dim_prev;
   logic [REM_BITS-1:0]   yr_up;
   logic [REM_BITS-1:0]   yr_dn;

   always_comb begin
      leap     = is_leap(yr400);
      dim      = days_in(month, leap);
      dim_prev = days_in(month - 4'd1, leap);
      yr_up    = (yr400 == REM_TOP) ? '0 : yr400 + 1'b1;
      yr_dn    = (yr400 == '0) ? REM_TOP : yr400 - 1'b1;

      day_nx   = day;
      month_nx = month;
      year_nx  = year;
      yr400_nx = yr400;
      clip     = 1'b0;

      if (!ctl.back) begin
         if (!ctl.months && (day != dim)) begin
            day_nx = day + 1'b1;
         end else begin
            if (!ctl.months) begin
               day_nx = DAY_FIRST;
            end
            if (month == MONTH_DEC) begin
               if (year == YEAR_TOP) begin
                  // saturate at december of the top year (on its last day for a day step)
                  clip     = 1'b1;
                  day_nx   = ctl.months ? day : DAY_DEC_LAST;
               end else begin
                  month_nx = MONTH_JAN;
                  year_nx  = year + 1'b1;
                  yr400_nx = yr_up;
               end
            end else begin
               month_nx = month + 1'b1;
            end
         end
      end else begin
         if (!ctl.months && (day != DAY_FIRST)) begin
            day_nx = day - 1'b1;
         end else if (month == MONTH_JAN) begin
            if (year == YEAR_ONE) begin
               // fell below year one: pin to the first day
               clip   = 1'b1;
               day_nx = DAY_FIRST;
            end else begin
               month_nx = MONTH_DEC;
               year_nx  = year - 1'b1;
               yr400_nx = yr_dn;
               if (!ctl.months) begin
                  day_nx = DAY_DEC_LAST;
               end
            end
         end else begin
            month_nx = month - 1'b1;
            if (!ctl.months) begin
               day_nx = dim_prev;
            end
         end
      end
   end

endmodule

// ===== design/cds_checker.sv =====
`include "calendar_date_stepper_top_macros.svh"

module cds_checker #(
   parameter int YEAR_BITS = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [1:0]                        req_op,
   input logic                              rsp_valid,
   input logic [cds_pkg::DAY_BITS-1:0]      rsp_day_out,
   input logic [cds_pkg::MONTH_BITS-1:0]    rsp_month_out,
   input logic [YEAR_BITS-1:0]              rsp_year_out,
   input logic                              rsp_rejected,
   input logic                              rsp_clipped
);
   import cds_pkg::*;

   logic accept;
   logic load_accept;
   logic date_ok;

   assign accept      = start && !busy;
   assign load_accept = accept && (op_type'(req_op) == OP_LOAD);
   assign date_ok     = (rsp_month_out >= MONTH_JAN) && (rsp_month_out <= MONTH_DEC)
                        && (rsp_day_out >= DAY_FIRST) && (rsp_year_out != '0);

   // a request either answers at once or keeps the block busy
   `CDS_ASSERT_NEXT(a_accept_engages, clock, reset, accept, busy || rsp_valid, "request dropped")

   // a load always runs the leap check first
   `CDS_ASSERT_NEXT(a_load_busy, clock, reset, load_accept, busy && !rsp_valid, "load answered early")

   // no result without a request in flight
   `CDS_ASSERT(a_rsp_has_req, clock, reset, rsp_valid |-> $past(accept || busy), "spurious result")

   `CDS_ASSERT(a_one_flag, clock, reset, rsp_valid |-> !(rsp_rejected && rsp_clipped), "both flags set")

   `CDS_ASSERT(a_date_range, clock, reset, rsp_valid |-> date_ok, "date out of range")

endmodule

bind calendar_date_stepper_top cds_checker #(.YEAR_BITS(YEAR_BITS)) u_cds_checker (.*);

// ===== bench/date_checker.sv =====
module date_checker #(
   parameter int YEAR_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [1:0]                           req_op,
   input  logic signed [cds_pkg::AMT_BITS-1:0]  req_amount,
   input  logic [cds_pkg::DAY_BITS-1:0]         req_new_day,
   input  logic [cds_pkg::MONTH_BITS-1:0]       req_new_month,
   input  logic [cds_pkg::NEW_YEAR_BITS-1:0]    req_new_year,
   input  logic                                 rsp_valid,
   input  logic [cds_pkg::DAY_BITS-1:0]         rsp_day_out,
   input  logic [cds_pkg::MONTH_BITS-1:0]       rsp_month_out,
   input  logic [YEAR_BITS-1:0]                 rsp_year_out,
   input  logic                                 rsp_rejected,
   input  logic                                 rsp_clipped,
   output int                                   fail_count,
   output int                                   outstanding
);
   import cds_pkg::*;

   localparam longint LAST_YEAR = (64'd1 << YEAR_BITS) - 1;

   typedef struct packed {
      logic [DAY_BITS-1:0]   day;
      logic [MONTH_BITS-1:0] month;
      logic [YEAR_BITS-1:0]  year;
      logic                  rejected;
      logic                  clipped;
   } date_result_type;

   // date the block should hold after every accepted request
   logic [DAY_BITS-1:0]   cal_day;
   logic [MONTH_BITS-1:0] cal_month;
   logic [YEAR_BITS-1:0]  cal_year;

   date_result_type expected_dates[$];

   function automatic bit leap_year(input longint y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int month_days(input int m, input longint y);
      int len;
      case (m)
         2:             len = leap_year(y) ? 29 : 28;
         4, 6, 9, 11:   len = 30;
         default:       len = 31;
      endcase
      return len;
   endfunction

   function automatic date_result_type advance_date(input op_type op, input int amt,
                                                    input int nd, input int nm,
                                                    input longint ny);
      int              d;
      int              m;
      int              n;
      longint          y;
      bit              rej;
      bit              clip;
      date_result_type res;
      d    = int'(cal_day);
      m    = int'(cal_month);
      y    = longint'(cal_year);
      n    = amt;
      rej  = 1'b0;
      clip = 1'b0;
      case (op)
         OP_LOAD: begin
            if (ny >= 1 && ny <= LAST_YEAR && nm >= 1 && nm <= 12 &&
                nd >= 1 && nd <= month_days(nm, ny)) begin
               d = nd;
               m = nm;
               y = ny;
            end else begin
               rej = 1'b1;
            end
         end
         OP_ADD_DAYS: begin
            while (n > 0 && !clip) begin
               n--;
               d++;
               if (d > month_days(m, y)) begin
                  d = 1;
                  m++;
                  if (m > 12) begin
                     if (y >= LAST_YEAR) begin
                        d    = 31;
                        m    = 12;
                        y    = LAST_YEAR;
                        clip = 1'b1;
                     end else begin
                        m = 1;
                        y++;
                     end
                  end
               end
            end
            while (n < 0 && !clip) begin
               n++;
               d--;
               if (d == 0) begin
                  m--;
                  if (m == 0) begin
                     if (y <= 1) begin
                        m    = 1;
                        y    = 1;
                        clip = 1'b1;
                     end else begin
                        y--;
                        m = 12;
                     end
                  end
                  d = clip ? 1 : month_days(m, y);
               end
            end
         end
         OP_ADD_MONTHS: begin
            while (n > 0 && !clip) begin
               n--;
               m++;
               if (m > 12) begin
                  if (y >= LAST_YEAR) begin
                     m    = 12;
                     y    = LAST_YEAR;
                     clip = 1'b1;
                  end else begin
                     m = 1;
                     y++;
                  end
               end
            end
            while (n < 0 && !clip) begin
               n++;
               m--;
               if (m == 0) begin
                  if (y <= 1) begin
                     d    = 1;
                     m    = 1;
                     y    = 1;
                     clip = 1'b1;
                  end else begin
                     y--;
                     m = 12;
                  end
               end
            end
         end
         default: begin
            y = y + n;
            if (y < 1) begin
               d    = 1;
               m    = 1;
               y    = 1;
               clip = 1'b1;
            end else if (y > LAST_YEAR) begin
               y    = LAST_YEAR;
               clip = 1'b1;
            end
         end
      endcase
      // month and year moves clamp the day, a no-op for the other commands
      if (d > month_days(m, y)) begin
         d = month_days(m, y);
      end
      cal_day      = DAY_BITS'(d);
      cal_month    = MONTH_BITS'(m);
      cal_year     = YEAR_BITS'(y);
      res.day      = DAY_BITS'(d);
      res.month    = MONTH_BITS'(m);
      res.year     = YEAR_BITS'(y);
      res.rejected = rej;
      res.clipped  = clip;
      return res;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
      cal_day     = 1;
      cal_month   = 1;
      cal_year    = 1;
   end

   always @(posedge clock) begin
      date_result_type want;
      if (!reset) begin
         // a result always belongs to an earlier request, so retire before queuing
         if (rsp_valid) begin
            if (expected_dates.size() == 0) begin
               $display("%0t: result with no request pending: day %0d month %0d year %0d",
                        $time, rsp_day_out, rsp_month_out, rsp_year_out);
               fail_count++;
            end else begin
               want = expected_dates.pop_front();
               check_field("day_out", 32'(want.day), 32'(rsp_day_out));
               check_field("month_out", 32'(want.month), 32'(rsp_month_out));
               check_field("year_out", 32'(want.year), 32'(rsp_year_out));
               check_field("rejected", 32'(want.rejected), 32'(rsp_rejected));
               check_field("clipped", 32'(want.clipped), 32'(rsp_clipped));
            end
         end
         if (start && !busy) begin
            expected_dates.push_back(advance_date(op_type'(req_op), int'(req_amount),
                                                  int'(req_new_day), int'(req_new_month),
                                                  longint'(req_new_year)));
         end
      end
      outstanding = expected_dates.size();
   end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   import cds_pkg::*;

   localparam int YEAR_BITS = 16;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [1:0]                  req_op;
   logic signed [AMT_BITS-1:0]  req_amount;
   logic [DAY_BITS-1:0]         req_new_day;
   logic [MONTH_BITS-1:0]       req_new_month;
   logic [NEW_YEAR_BITS-1:0]    req_new_year;
   logic                        rsp_valid;
   logic [DAY_BITS-1:0]         rsp_day_out;
   logic [MONTH_BITS-1:0]       rsp_month_out;
   logic [YEAR_BITS-1:0]        rsp_year_out;
   logic                        rsp_rejected;
   logic                        rsp_clipped;
   int                          fail_count;
   int                          outstanding;
   int                          burst_left = 0;

   calendar_date_stepper_top #(.YEAR_BITS(YEAR_BITS)) u_top (.*);

   date_checker #(.YEAR_BITS(YEAR_BITS)) u_checker (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // sender runs in bursts; between bursts it idles with junk on the fields
   task automatic send_request(input op_type op, input int amt, input int d,
                               input int m, input int y);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 30);
         @(negedge clock);
         start         = 1'b0;
         req_op        = 2'($urandom_range(0, 3));
         req_amount    = AMT_BITS'($urandom_range(0, 8191));
         req_new_day   = DAY_BITS'($urandom_range(0, 31));
         req_new_month = MONTH_BITS'($urandom_range(0, 15));
         req_new_year  = NEW_YEAR_BITS'($urandom_range(0, 65535));
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      start         = 1'b1;
      req_op        = op;
      req_amount    = AMT_BITS'(amt);
      req_new_day   = DAY_BITS'(d);
      req_new_month = MONTH_BITS'(m);
      req_new_year  = NEW_YEAR_BITS'(y);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      op_type op;
      int     sel;
      int     sub;
      int     amt;
      int     d;
      int     m;
      int     y;
      reset         = 1'b1;
      start         = 1'b0;
      req_op        = OP_LOAD;
      req_amount    = '0;
      req_new_day   = '0;
      req_new_month = '0;
      req_new_year  = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // loads: leap days, short months, each field out of range
      send_request(OP_LOAD, 0, 29, 2, 2000);
      send_request(OP_LOAD, 0, 29, 2, 1900);
      send_request(OP_LOAD, 0, 31, 4, 2023);
      send_request(OP_LOAD, 0, 0, 6, 2023);
      send_request(OP_LOAD, 0, 10, 0, 2023);
      send_request(OP_LOAD, 0, 10, 6, 0);
      // day clamp after month and year moves
      send_request(OP_LOAD, 0, 31, 1, 2024);
      send_request(OP_ADD_MONTHS, 1, 0, 0, 0);
      send_request(OP_ADD_YEARS, 1, 0, 0, 0);
      send_request(OP_ADD_DAYS, 0, 0, 0, 0);
      send_request(OP_ADD_MONTHS, 0, 0, 0, 0);
      send_request(OP_ADD_YEARS, 0, 0, 0, 0);
      // saturation at the top year
      send_request(OP_LOAD, 0, 31, 12, 65535);
      send_request(OP_ADD_DAYS, 1, 0, 0, 0);
      send_request(OP_ADD_MONTHS, 1, 0, 0, 0);
      send_request(OP_ADD_YEARS, 4095, 0, 0, 0);
      // landing on the first date is fine, going past it clips
      send_request(OP_LOAD, 0, 2, 1, 1);
      send_request(OP_ADD_DAYS, -1, 0, 0, 0);
      send_request(OP_ADD_DAYS, -1, 0, 0, 0);
      send_request(OP_ADD_MONTHS, -1, 0, 0, 0);
      // largest amounts
      send_request(OP_LOAD, 0, 15, 6, 2000);
      send_request(OP_ADD_DAYS, 4095, 0, 0, 0);
      send_request(OP_ADD_DAYS, -4096, 0, 0, 0);
      send_request(OP_ADD_MONTHS, 4095, 0, 0, 0);
      send_request(OP_ADD_MONTHS, -4096, 0, 0, 0);
      send_request(OP_ADD_YEARS, -4096, 0, 0, 0);
      drain_results();

      for (int i = 0; i < 1100; i++) begin
         sel = $urandom_range(0, 99);
         sub = $urandom_range(0, 99);
         d   = $urandom_range(0, 31);
         m   = $urandom_range(0, 15);
         y   = $urandom_range(0, 65535);
         amt = 0;
         if (sel < 20) begin
            op = OP_LOAD;
            if (sub < 75) begin
               case ($urandom_range(0, 7))
                  0:       y = $urandom_range(1, 5);
                  1:       y = 100 * $urandom_range(1, 24);
                  2:       y = 65535 - $urandom_range(0, 3);
                  3, 4, 5: y = $urandom_range(1, 3000);
                  default: y = $urandom_range(1, 65535);
               endcase
               m = $urandom_range(1, 12);
               d = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
            end else if (sub < 90) begin
               case ($urandom_range(0, 2))
                  0:       d = 0;
                  1:       m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
                  default: y = 0;
               endcase
            end
         end else begin
            op = (sel < 55) ? OP_ADD_DAYS : (sel < 80) ? OP_ADD_MONTHS : OP_ADD_YEARS;
            // long day and month walks are rare, year moves cost the same at any size
            if (op == OP_ADD_YEARS) begin
               amt = (sub < 50) ? int'($urandom_range(0, 120)) - 60
                                : int'($urandom_range(0, 8191)) - 4096;
            end else if (sub < 65) begin
               amt = int'($urandom_range(0, 80)) - 40;
            end else if (sub < 93) begin
               amt = int'($urandom_range(0, 800)) - 400;
            end else begin
               amt = int'($urandom_range(0, 8191)) - 4096;
            end
         end
         send_request(op, amt, d, m, y);
         if (i % 250 == 249) begin
            drain_results();
         end
      end

      drain_results();
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // well past the slowest legal run of this stimulus
   initial begin
      #500_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/cds_pkg.sv
design/cds_rem400.sv
design/cds_step.sv
design/calendar_date_stepper_top.sv
design/cds_checker.sv
bench/date_checker.sv
bench/tb_top.sv
